>>> hw/rtl/mlfq_three_level_scheduler_macros.svh
// assertion macros for the three-level feedback queue scheduler
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef MLFQ_THREE_LEVEL_SCHEDULER_MACROS_SVH
`define MLFQ_THREE_LEVEL_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define MLFQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent in this cycle implies consequent in the next one
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MLFQ_ASSERT_ALWAYS(lbl, cond, msg)
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mlfq_pkg.sv
// shared constants for the three-level feedback queue scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;
  // default sizing
  localparam int MAX_TASKS_DEF  = 8;
  localparam int BURST_BITS_DEF = 16;
  localparam int LEVELS         = 3;

  // quantum reset values
  localparam logic [15:0] QUANTUM_FIRST_RESET  = 16'd5;
  localparam logic [15:0] QUANTUM_SECOND_RESET = 16'd10;

  // command codes
  localparam logic CMD_READY    = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  // configuration register indexes
  localparam logic REG_QUANTUM_FIRST  = 1'b0;
  localparam logic REG_QUANTUM_SECOND = 1'b1;

  // level codes, zero based
  localparam logic [1:0] LVL_FIRST  = 2'd0;
  localparam logic [1:0] LVL_SECOND = 2'd1;
  localparam logic [1:0] LVL_THIRD  = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/mlfq_three_level_scheduler.sv
// three-level feedback queue scheduler: queue slot memory, burst memory, control
// depends on mlfq_pkg and mlfq_three_level_scheduler_macros.svh
// ready command: no result; busy stays low, the next command may follow at once.
// dispatch command: result strobed on done after the slot read, the burst read, and then
//   compare/subtract and write back; busy is high from the accepting edge until the result
//   is strobed, so no new command is taken while a dispatch is in flight.
// empty dispatch: idle result on done in the cycle after the accepting edge, no busy time.
// the receiver cannot stall: each result is shown for one cycle only.
// reset (rst, synchronous): queues empty, all tasks at level 1, quanta 5 and 10;
//   slot and burst memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "mlfq_three_level_scheduler_macros.svh"
module mlfq_three_level_scheduler #(
  parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF,
  parameter int BURST_BITS = mlfq_pkg::BURST_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [2:0]  task_number,
  input  wire logic [15:0] burst_length,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // result channel
  output logic             done,
  output logic [2:0]       chosen_task,
  output logic [15:0]      run_time,
  output logic [1:0]       level_served,
  output logic             burst_finished,
  output logic [1:0]       demoted_level,
  output logic             idle
);
  import mlfq_pkg::*;

  localparam int TW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int SLOTS = LEVELS * MAX_TASKS;
  localparam int AW    = $clog2(SLOTS);
  localparam int QW    = (BURST_BITS > 16) ? BURST_BITS : 16;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TASK  = 2'd1;
  localparam logic [1:0] S_BURST = 2'd2;

  // state and storage
  logic [1:0]            state, state_next;
  logic [15:0]           quantum_first, quantum_second;
  logic [TW-1:0]         heads [LEVELS];
  logic [TW-1:0]         heads_next [LEVELS];
  logic [CW-1:0]         counts [LEVELS];
  logic [CW-1:0]         counts_next [LEVELS];
  logic [1:0]            task_level [MAX_TASKS];
  logic [TW-1:0]         slot_mem [SLOTS];
  logic [BURST_BITS-1:0] burst_mem [MAX_TASKS];
  logic [TW-1:0]         slot_rd;
  logic [BURST_BITS-1:0] burst_rd;
  logic [1:0]            lvl;

  // control signals
  logic                  accept, any_queued, in_range;
  logic [1:0]            lvl_sel, ready_lvl, push_lvl;
  logic [TW-1:0]         ready_task;
  logic [AW-1:0]         slot_raddr, slot_waddr;
  logic [TW-1:0]         slot_wdata;
  logic                  slot_we, burst_we;
  logic [TW-1:0]         burst_waddr;
  logic [BURST_BITS-1:0] burst_wdata;
  logic                  push_ok;
  logic [TW:0]           push_sum;
  logic [TW-1:0]         push_pos;
  logic [15:0]           quantum_sel;
  logic [QW-1:0]         rem_x, quantum_x, run_x;
  logic                  demote;
  logic                  level_we;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign any_queued = (counts[0] != '0) || (counts[1] != '0) || (counts[2] != '0);
  assign in_range   = (int'(task_number) < MAX_TASKS);
  assign ready_task = TW'(task_number);
  assign ready_lvl  = task_level[ready_task] - 2'd1;

  // highest non-empty level
  always_comb begin
    if (counts[0] != '0) begin
      lvl_sel = LVL_FIRST;
    end else if (counts[1] != '0) begin
      lvl_sel = LVL_SECOND;
    end else begin
      lvl_sel = LVL_THIRD;
    end
  end

  assign slot_raddr = AW'(int'(lvl_sel) * MAX_TASKS) + AW'(heads[lvl_sel]);

  // grant computation on the fetched burst
  assign quantum_sel = (lvl == LVL_FIRST) ? quantum_first : quantum_second;
  assign rem_x       = QW'(burst_rd);
  assign quantum_x   = QW'(quantum_sel);
  assign demote      = (lvl != LVL_THIRD) && (rem_x > quantum_x);
  assign run_x       = demote ? quantum_x : rem_x;

  // fifo tail position for the level being pushed
  assign push_lvl = (state == S_BURST) ? (lvl + 2'd1) : ready_lvl;
  assign push_ok  = counts[push_lvl] < CW'(MAX_TASKS);
  always_comb begin
    push_sum = (TW+1)'(heads[push_lvl]) + (TW+1)'(counts[push_lvl]);
    if (push_sum >= (TW+1)'(MAX_TASKS)) begin
      push_sum = push_sum - (TW+1)'(MAX_TASKS);
    end
    push_pos = push_sum[TW-1:0];
  end

  // next-state, pointer and memory write control
  always_comb begin
    state_next  = state;
    heads_next  = heads;
    counts_next = counts;
    slot_we     = 1'b0;
    slot_waddr  = AW'(int'(push_lvl) * MAX_TASKS) + AW'(push_pos);
    slot_wdata  = ready_task;
    burst_we    = 1'b0;
    burst_waddr = ready_task;
    burst_wdata = BURST_BITS'(burst_length);
    level_we    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (command == CMD_READY) && in_range) begin
          if (push_ok) begin
            slot_we  = 1'b1;
            burst_we = 1'b1;
            counts_next[push_lvl] = counts[push_lvl] + CW'(1);
          end
        end else if (accept && (command == CMD_DISPATCH) && any_queued) begin
          // pop the head now; the slot is read at this edge
          counts_next[lvl_sel] = counts[lvl_sel] - CW'(1);
          if (heads[lvl_sel] == TW'(MAX_TASKS - 1)) begin
            heads_next[lvl_sel] = '0;
          end else begin
            heads_next[lvl_sel] = heads[lvl_sel] + TW'(1);
          end
          state_next = S_TASK;
        end
      end
      S_TASK: begin
        state_next = S_BURST;
      end
      S_BURST: begin
        burst_we    = 1'b1;
        burst_waddr = slot_rd;
        burst_wdata = demote ? BURST_BITS'(rem_x - quantum_x) : '0;
        slot_wdata  = slot_rd;
        if (demote) begin
          level_we = 1'b1;
          if (push_ok) begin
            slot_we = 1'b1;
            counts_next[push_lvl] = counts[push_lvl] + CW'(1);
          end
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      quantum_first  <= QUANTUM_FIRST_RESET;
      quantum_second <= QUANTUM_SECOND_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_level[i] <= 2'd1;
      end
    end else begin
      state  <= state_next;
      heads  <= heads_next;
      counts <= counts_next;
      if (cfg_we && (cfg_index == REG_QUANTUM_FIRST)) begin
        quantum_first <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_QUANTUM_SECOND)) begin
        quantum_second <= cfg_data;
      end
      if (level_we) begin
        task_level[slot_rd] <= lvl + 2'd2;
      end
    end
  end

  // dispatch level held for the grant
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl <= lvl_sel;
    end
  end

  // queue slot memory; a write can share its address with a read only on a ready command, whose read value is unused
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (accept) begin
      slot_rd <= slot_mem[slot_raddr];
    end
  end

  // remaining burst memory
  always_ff @(posedge clk) begin
    if (burst_we) begin
      burst_mem[burst_waddr] <= burst_wdata;
    end
    if (state == S_TASK) begin
      burst_rd <= burst_mem[slot_rd];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (command == CMD_DISPATCH) && !any_queued) || (state == S_BURST);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && (command == CMD_DISPATCH) && !any_queued) begin
      chosen_task    <= '0;
      run_time       <= '0;
      level_served   <= '0;
      burst_finished <= 1'b0;
      demoted_level  <= '0;
      idle           <= 1'b1;
    end else if (state == S_BURST) begin
      chosen_task    <= 3'(slot_rd);
      run_time       <= run_x[15:0];
      level_served   <= lvl + 2'd1;
      burst_finished <= !demote;
      demoted_level  <= demote ? (lvl + 2'd2) : (lvl + 2'd1);
      idle           <= 1'b0;
    end
  end

  // checks
  `MLFQ_ASSERT_ALWAYS(a_count_bound, (counts[0] <= CW'(MAX_TASKS)) && (counts[1] <= CW'(MAX_TASKS)) && (counts[2] <= CW'(MAX_TASKS)), "queue count above capacity")
  `MLFQ_ASSERT_NEXT(a_task_then_burst, state == S_TASK, state == S_BURST, "burst fetch skipped")
  `MLFQ_ASSERT_ALWAYS(a_idle_zero, !(done && idle) || ((chosen_task == '0) && (run_time == '0) && (level_served == '0) && !burst_finished), "idle result carries data")
  `MLFQ_ASSERT_ALWAYS(a_level_step, !(done && !idle) || (burst_finished ? (demoted_level == level_served) : (demoted_level == level_served + 2'd1)), "demoted level inconsistent")
endmodule
`default_nettype wire
